>>> hdl/tlf_pkg.sv
`default_nettype none
package tlf_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_NUMBER_ALL       = 3'd0;
  localparam logic [2:0] REG_NUMBER_NONBLANK  = 3'd1;
  localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd2;
  localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd3;
  localparam logic [2:0] REG_SHOW_ENDS        = 3'd4;
  localparam logic [2:0] REG_SHOW_TABS        = 3'd5;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_UPPER_I = 8'h49;
  localparam logic [7:0] CH_DEL     = 8'd127;
  localparam logic [7:0] CH_HI_LOW  = 8'd128;
  localparam logic [7:0] CH_HI_TOP  = 8'd160;
  localparam logic [7:0] CH_CTL_TOP = 8'd32;
  localparam logic [7:0] XOR_CTL    = 8'b0100_0000;
  localparam logic [7:0] XOR_HIGH   = 8'b1100_0000;
  localparam logic [3:0] ASCII_ZERO_HI = 4'h3;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_nonprinting;
    logic show_ends;
    logic show_tabs;
  } cfg_t;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_NUMBER,
    PFX_SPACES
  } prefix_t;

  // one queued command: optional line prefix, then one or two body bytes
  typedef struct packed {
    prefix_t    prefix;
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DIGIT,
    PH_TAB,
    PH_B0,
    PH_B1
  } phase_t;

endpackage
`default_nettype wire

>>> hdl/text_stream_line_formatter_unit.sv
// Channel   Direction  Ports                                  Beat holds
// s_axis    in         s_tvalid s_tready s_tdata s_tuser      one raw text byte
// m_axis    out        m_tvalid m_tready m_tdata m_tlast      one formatted byte
// cfg       in         cfg_we cfg_index cfg_data              one mode bit
//
// The back end sends one output beat per cycle unless stalled and loads the next
// command from the four-entry queue on the last beat of the current one. A plain
// byte gives one beat, an escaped byte two and a line number adds NUMBER_DIGITS + 1.
// With the back end idle, an accepted byte passes the queue and the phase and output
// registers before m_tvalid rises. The front end accepts a byte per cycle while the
// queue has room. Reset (rst, synchronous) clears modes, sets the line number to one
// and empties the queue. Output stalls back up through the queue to s_tready.
`default_nettype none
module text_stream_line_formatter_unit #(
  parameter int NUMBER_DIGITS = 6
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tuser,   // [0] first_of_file
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [0:0] cfg_data
);
  import tlf_pkg::*;

  localparam int BW = 4 * NUMBER_DIGITS;
  localparam int QW = $bits(cmd_t) + BW;

  cfg_t          cfg;
  logic          push;
  cmd_t          push_cmd;
  logic [BW-1:0] push_num;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  logic [QW-1:0] q_head;
  cmd_t          q_cmd;
  logic [BW-1:0] q_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUMBER_ALL:       cfg.number_all       <= cfg_data[0];
        REG_NUMBER_NONBLANK:  cfg.number_nonblank  <= cfg_data[0];
        REG_SQUEEZE_BLANK:    cfg.squeeze_blank    <= cfg_data[0];
        REG_SHOW_NONPRINTING: cfg.show_nonprinting <= cfg_data[0];
        REG_SHOW_ENDS:        cfg.show_ends        <= cfg_data[0];
        REG_SHOW_TABS:        cfg.show_tabs        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tlf_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_first (s_tuser),
    .push     (push),
    .push_cmd (push_cmd),
    .push_num (push_num),
    .q_full   (q_full)
  );

  tlf_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_cmd, push_num}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  assign q_cmd = q_head[QW-1 -: $bits(cmd_t)];
  assign q_num = q_head[BW-1:0];

  tlf_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_num     (q_num),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
`default_nettype wire

>>> hdl/tlf_front.sv
`default_nettype none
module tlf_front #(
  parameter int NUMBER_DIGITS = 6
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire tlf_pkg::cfg_t                cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_byte,
  input  wire logic                         in_first,
  output logic                              push,
  output tlf_pkg::cmd_t                     push_cmd,
  output logic [4*NUMBER_DIGITS-1:0]        push_num,
  input  wire logic                         q_full
);
  import tlf_pkg::*;

  localparam int BW = 4 * NUMBER_DIGITS;

  logic          at_line_start, at_line_start_next;
  logic [BW-1:0] line_count, line_count_next;
  logic          prev_blank, prev_blank_next;

  logic          accept;
  logic          ls;
  logic [BW-1:0] cnt;
  logic [BW-1:0] cnt_inc;
  logic          blank;
  logic          drop;
  logic          do_inc;
  logic          escaping;
  logic          nines_below;
  logic [3:0]    dig;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // saturating BCD increment: a digit steps when every lower digit is nine
  always_comb begin
    cnt_inc     = cnt;
    nines_below = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      dig = cnt[4*i +: 4];
      if (nines_below)
        cnt_inc[4*i +: 4] = (dig == 4'd9) ? 4'd0 : dig + 4'd1;
      nines_below = nines_below && (dig == 4'd9);
    end
    if (nines_below)
      cnt_inc = cnt;
  end

  always_comb begin
    ls       = in_first || at_line_start;
    cnt      = in_first ? BW'(1) : line_count;
    blank    = (in_byte == CH_NL);
    escaping = cfg.show_nonprinting || cfg.show_ends || cfg.show_tabs;
    drop     = 1'b0;
    do_inc   = 1'b0;

    push_cmd.prefix = PFX_NONE;
    push_cmd.two    = 1'b0;
    push_cmd.b0     = in_byte;
    push_cmd.b1     = in_byte;
    push_num        = cnt;
    prev_blank_next = prev_blank;

    if (ls) begin
      if (cfg.squeeze_blank && blank && prev_blank) begin
        drop = 1'b1;
      end else begin
        prev_blank_next = cfg.squeeze_blank && blank;
        if (cfg.number_nonblank) begin
          if (!blank) begin
            push_cmd.prefix = PFX_NUMBER;
            do_inc          = 1'b1;
          end else if (cfg.show_ends) begin
            push_cmd.prefix = PFX_SPACES;
          end
        end else if (cfg.number_all) begin
          push_cmd.prefix = PFX_NUMBER;
          do_inc          = 1'b1;
        end
      end
    end

    if (escaping) begin
      if (cfg.show_tabs && in_byte == CH_TAB) begin
        push_cmd.two = 1'b1;
        push_cmd.b0  = CH_CARET;
        push_cmd.b1  = CH_UPPER_I;
      end else if ((in_byte < CH_CTL_TOP && in_byte != CH_NL && in_byte != CH_TAB)
                   || in_byte == CH_DEL) begin
        push_cmd.two = 1'b1;
        push_cmd.b0  = CH_CARET;
        push_cmd.b1  = in_byte ^ XOR_CTL;
      end else if (in_byte >= CH_HI_LOW && in_byte < CH_HI_TOP) begin
        push_cmd.two = 1'b1;
        push_cmd.b0  = CH_CARET;
        push_cmd.b1  = in_byte ^ XOR_HIGH;
      end else if (cfg.show_ends && blank) begin
        push_cmd.two = 1'b1;
        push_cmd.b0  = CH_DOLLAR;
        push_cmd.b1  = CH_NL;
      end
    end

    push = accept && !drop;

    // a squeezed line keeps the line start pending
    at_line_start_next = drop ? 1'b1 : blank;
    line_count_next    = do_inc ? cnt_inc : cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start <= 1'b1;
      line_count    <= BW'(1);
      prev_blank    <= 1'b0;
    end else if (accept) begin
      at_line_start <= at_line_start_next;
      line_count    <= line_count_next;
      prev_blank    <= prev_blank_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/tlf_queue.sv
`default_nettype none
module tlf_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head_data
);
  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_pop;

  assign full       = (count == (AW+1)'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push)
      mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= wr_ptr + AW'(1);
      if (do_pop)
        rd_ptr <= rd_ptr + AW'(1);
      if (push && !do_pop)
        count <= count + (AW+1)'(1);
      else if (!push && do_pop)
        count <= count - (AW+1)'(1);
    end
  end

endmodule
`default_nettype wire

>>> hdl/tlf_back.sv
`default_nettype none
module tlf_back #(
  parameter int NUMBER_DIGITS = 6
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_valid,
  input  wire tlf_pkg::cmd_t           q_cmd,
  input  wire logic [4*NUMBER_DIGITS-1:0] q_num,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [7:0]                   out_byte,
  output logic                         out_last
);
  import tlf_pkg::*;

  localparam int BW = 4 * NUMBER_DIGITS;
  localparam int CW = $clog2(NUMBER_DIGITS + 1);

  phase_t        phase, phase_next;
  logic [BW-1:0] num_sh, num_sh_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          started, started_next;
  logic          spaces, spaces_next;
  cmd_t          cmd, cmd_next;

  logic          out_free;
  logic          emit;
  logic          final_beat;
  logic [7:0]    beat_byte;
  logic [3:0]    digit;

  assign out_free = !out_valid || out_ready;
  assign digit    = num_sh[BW-1 -: 4];

  always_comb begin
    phase_next   = phase;
    num_sh_next  = num_sh;
    cnt_next     = cnt;
    started_next = started;
    spaces_next  = spaces;
    cmd_next     = cmd;
    beat_byte    = cmd.b0;
    final_beat   = 1'b0;
    emit         = (phase != PH_IDLE) && out_free;

    case (phase)
      PH_DIGIT: begin
        if (spaces)
          beat_byte = CH_SPACE;
        else if (started || digit != 4'd0 || cnt == CW'(1))
          beat_byte = {ASCII_ZERO_HI, digit};
        else
          beat_byte = CH_SPACE;
        if (emit) begin
          started_next = started || (digit != 4'd0);
          num_sh_next  = num_sh << 4;
          cnt_next     = cnt - CW'(1);
          if (cnt == CW'(1))
            phase_next = PH_TAB;
        end
      end
      PH_TAB: begin
        beat_byte = CH_TAB;
        if (emit)
          phase_next = PH_B0;
      end
      PH_B0: begin
        beat_byte  = cmd.b0;
        final_beat = !cmd.two;
        if (emit)
          phase_next = cmd.two ? PH_B1 : PH_IDLE;
      end
      PH_B1: begin
        beat_byte  = cmd.b1;
        final_beat = 1'b1;
        if (emit)
          phase_next = PH_IDLE;
      end
      default: begin
        beat_byte = cmd.b0;
      end
    endcase

    // take the next command as soon as the current one hands out its last beat
    q_pop = q_valid && ((phase == PH_IDLE) || (emit && final_beat));
    if (q_pop) begin
      cmd_next     = q_cmd;
      num_sh_next  = q_num;
      cnt_next     = CW'(NUMBER_DIGITS);
      started_next = 1'b0;
      spaces_next  = (q_cmd.prefix == PFX_SPACES);
      phase_next   = (q_cmd.prefix == PFX_NONE) ? PH_B0 : PH_DIGIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)
      phase <= PH_IDLE;
    else
      phase <= phase_next;
  end

  always_ff @(posedge clk) begin
    num_sh  <= num_sh_next;
    cnt     <= cnt_next;
    started <= started_next;
    spaces  <= spaces_next;
    cmd     <= cmd_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      out_byte <= beat_byte;
      out_last <= final_beat;
    end
  end

endmodule
`default_nettype wire

>>> test/tb_text_stream_line_formatter_unit.sv
`timescale 1ns / 100ps
module tb_text_stream_line_formatter_unit;
  import tlf_pkg::*;

  localparam int DIGITS      = 6;
  localparam int DRAIN       = 4 * DIGITS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 30;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } text_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } fmt_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_NUMBER_ALL;
  logic [0:0] cfg_data = 1'b0;

  text_item_t pending_text[$];
  fmt_beat_t  expected_fmt[$];
  int         errors = 0;
  int         cycles = 0;
  int         queued = 0;

  // formatter state as seen from outside
  cfg_t                  mode = '0;
  logic                  line_start = 1'b1;
  logic [4*DIGITS-1:0]   line_bcd = (4*DIGITS)'(1);
  logic                  prev_blank = 1'b0;

  text_stream_line_formatter_unit #(.NUMBER_DIGITS(DIGITS)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_text_stream_line_formatter_unit failed");
      $finish;
    end
  end

  // right-aligned line number and tab, then advance the count (holds at all nines)
  task automatic emit_line_number(ref logic [7:0] run[$]);
    logic [3:0]          d;
    logic [4*DIGITS-1:0] nxt;
    bit                  lead;
    bit                  done;
    lead = 1'b0;
    for (int i = DIGITS - 1; i >= 0; i--) begin
      d = line_bcd[4*i +: 4];
      if (d != 0 || i == 0) lead = 1'b1;
      run.push_back(lead ? {ASCII_ZERO_HI, d} : CH_SPACE);
    end
    run.push_back(CH_TAB);
    nxt  = line_bcd;
    done = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      if (!done) begin
        if (nxt[4*i +: 4] < 4'd9) begin
          nxt[4*i +: 4] = nxt[4*i +: 4] + 4'd1;
          done = 1'b1;
        end else begin
          nxt[4*i +: 4] = 4'd0;
        end
      end
    end
    if (done) line_bcd = nxt;
  endtask

  task automatic format_text_byte(input logic [7:0] c, input logic first);
    logic [7:0] run[$];
    logic       blank;
    logic       esc;
    if (first) begin
      line_bcd   = (4*DIGITS)'(1);
      line_start = 1'b1;
    end
    if (line_start) begin
      blank = (c == CH_NL);
      if (mode.squeeze_blank && blank) begin
        // drop the repeated blank line; line start stays pending
        if (prev_blank) return;
        prev_blank = 1'b1;
      end else begin
        prev_blank = 1'b0;
      end
      if (mode.number_nonblank) begin
        if (!blank) begin
          emit_line_number(run);
        end else if (mode.show_ends) begin
          repeat (DIGITS) run.push_back(CH_SPACE);
          run.push_back(CH_TAB);
        end
      end else if (mode.number_all) begin
        emit_line_number(run);
      end
      line_start = 1'b0;
    end
    esc = mode.show_nonprinting | mode.show_ends | mode.show_tabs;
    if (esc && mode.show_tabs && c == CH_TAB) begin
      run.push_back(CH_CARET);
      run.push_back(CH_UPPER_I);
    end else if (esc && ((c < CH_CTL_TOP && c != CH_NL && c != CH_TAB) || c == CH_DEL)) begin
      run.push_back(CH_CARET);
      run.push_back(c ^ XOR_CTL);
    end else if (esc && c >= CH_HI_LOW && c < CH_HI_TOP) begin
      run.push_back(CH_CARET);
      run.push_back(c ^ XOR_HIGH);
    end else if (esc && mode.show_ends && c == CH_NL) begin
      run.push_back(CH_DOLLAR);
      run.push_back(CH_NL);
    end else begin
      run.push_back(c);
    end
    if (c == CH_NL) line_start = 1'b1;
    foreach (run[i]) expected_fmt.push_back('{ch: run[i], last: (i == run.size() - 1)});
  endtask

  // sender: bursts of random length, random gaps between them
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        format_text_byte(s_tdata, s_tuser);
        pending_text.pop_front();
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_text.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_text[0].data;
          s_tuser  <= pending_text[0].first;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: changing stall pattern, plus long hold-offs while input is still offered
  int rx_style = 0;
  int rx_tick  = 0;
  int rx_beats = 0;
  int rx_hold  = 0;
  int rx_long  = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_tick++;
      if (m_tvalid && m_tready) begin
        rx_beats++;
        if (rx_long < 2 && rx_beats > 150 * (rx_long + 1) && pending_text.size() > 16) begin
          rx_hold = 250;
          rx_long++;
        end
      end
      if (rx_tick % 50 == 0) rx_style = $urandom_range(0, 3);
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else begin
        case (rx_style)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= ($urandom_range(0, 1) == 1);
          default: m_tready <= (rx_tick % 4 < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    fmt_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_fmt.size() == 0) begin
        $error("out_byte: no beat expected, got %02h", m_tdata);
        errors++;
      end else begin
        want = expected_fmt.pop_front();
        if (m_tdata !== want.ch) begin
          $error("out_byte: expected %02h, got %02h", want.ch, m_tdata);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] data, input logic first);
    pending_text.push_back('{data: data, first: first});
    queued++;
  endtask

  // hold the sender back until everything owed has come out
  task automatic settle();
    while (pending_text.size() != 0 || s_tvalid || expected_fmt.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic apply_modes(input cfg_t m);
    logic [2:0] order [6];
    order = '{REG_NUMBER_ALL, REG_NUMBER_NONBLANK, REG_SQUEEZE_BLANK,
              REG_SHOW_NONPRINTING, REG_SHOW_ENDS, REG_SHOW_TABS};
    for (int r = 0; r < 6; r++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= order[r];
      cfg_data  <= m[5-r];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    mode = m;
  endtask

  // one text line with random content; empty length makes a blank line
  task automatic queue_line(input int len, input bit new_file);
    logic [7:0] c;
    int         pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6)       c = 8'($urandom_range(8'h20, 8'h7E));
      else if (pick == 6) c = CH_TAB;
      else if (pick == 7) c = 8'($urandom_range(0, 31));
      else if (pick == 8) c = 8'($urandom_range(127, 159));
      else                c = 8'($urandom_range(0, 255));
      push_byte(c, (i == 0 && new_file) || ($urandom_range(0, 39) == 0));
    end
    push_byte(CH_NL, len == 0 && new_file);
  endtask

  initial begin
    logic [7:0] dir_a [14];
    logic [7:0] dir_b [4];
    cfg_t       m;
    int         start;
    dir_a = '{8'h00, CH_TAB, 8'h1F, CH_DEL, 8'h80, 8'h9F, 8'hA0, 8'hFF,
              8'h41, CH_NL, CH_NL, CH_NL, CH_NL, 8'h42};
    dir_b = '{CH_NL, 8'h61, CH_NL, CH_NL};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // modes straight from reset: plain pass-through
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_NL, 1'b0);
    settle();

    // numbering, squeeze, caret escapes, new file in mid-line
    apply_modes(cfg_t'(6'b101101));
    foreach (dir_a[i]) push_byte(dir_a[i], 1'b0);
    push_byte(8'h43, 1'b1);
    push_byte(CH_NL, 1'b0);
    settle();

    // nonblank numbering overriding number_all, blank lines padded under show_ends
    apply_modes(cfg_t'(6'b110010));
    foreach (dir_b[i]) push_byte(dir_b[i], 1'b0);
    push_byte(CH_NL, 1'b1);
    settle();

    for (int p = 0; p < 8; p++) begin
      if (p == 0)      m = '1;
      else if (p == 1) m = '0;
      else             m = cfg_t'(6'($urandom_range(0, 63)));
      apply_modes(m);
      start = queued;
      while (queued - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 3) queue_line(0, $urandom_range(0, 11) == 0);
        else queue_line($urandom_range(1, 10), $urandom_range(0, 11) == 0);
      end
      settle();
    end

    if (expected_fmt.size() != 0) errors++;
    if (errors == 0) begin
      $display("tb_text_stream_line_formatter_unit passed");
    end else begin
      $display("tb_text_stream_line_formatter_unit failed");
    end
    $finish;
  end

endmodule
